@@ hdl/srts_pkg.sv @@
// ----------------------------------------------------------------------------
// srts_pkg
// Shared types and constants for the sticky recent target selector.
// ----------------------------------------------------------------------------
package srts_pkg;

  // Field widths
  localparam int ID_W      = 4;
  localparam int TIME_W    = 32;
  localparam int MASK_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  // Default table depth
  localparam int NUM_IDS_DEF = 16;

  // Operation codes
  localparam logic [1:0] OP_SIGHT   = 2'd0;
  localparam logic [1:0] OP_SELECT  = 2'd1;
  localparam logic [1:0] OP_REFRESH = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALLOWED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPIRE  = 2'd1;

  // Configuration reset values
  localparam logic [MASK_W-1:0] ALLOWED_RST = 16'hFFFF;
  localparam logic [TIME_W-1:0] EXPIRE_RST  = 32'd1000;

  // Input item
  typedef struct packed {
    logic [1:0]        operation;
    logic [ID_W-1:0]   target_id;
    logic [TIME_W-1:0] time_stamp;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [ID_W-1:0] focus_id;
    logic            focus_found;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic            accept;    // input item taken this cycle
    logic            walk_rd;   // read table entry at walk_idx
    logic            sweep_wr;  // write current time at walk_idx
    logic [ID_W-1:0] walk_idx;
    logic            resolve;   // settle focus and load result
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] in_op;     // operation of the offered item
    logic       out_free;  // result register can take a new item
  } dp_stat_t;

endpackage

@@ hdl/srts_ctrl.sv @@
// ----------------------------------------------------------------------------
// srts_ctrl
// Sequencer: accepts items, walks the table once per select, refresh or
// clear, lets the pipe drain after select or refresh and resolves a select.
// ----------------------------------------------------------------------------
module srts_ctrl import srts_pkg::*; #(
  parameter int NUM_IDS = NUM_IDS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  localparam int IDX_W = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_IDS - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_RESOLVE
  } state_t;

  state_t           state_r;
  logic [1:0]       op_r;
  logic [IDX_W-1:0] cnt_r;
  logic             drain_r;

  // Handshake and commands
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.accept   = in_valid && (state_r == ST_IDLE);
    cmd.walk_rd  = (state_r == ST_WALK) && (op_r != OP_CLEAR);
    cmd.sweep_wr = (state_r == ST_WALK) && (op_r == OP_CLEAR);
    cmd.walk_idx = ID_W'(cnt_r);
    cmd.resolve  = (state_r == ST_RESOLVE) && stat.out_free;
  end

  // State and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_SIGHT;
      cnt_r   <= '0;
      drain_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            op_r <= stat.in_op;
            cnt_r <= '0;
            if (stat.in_op != OP_SIGHT) state_r <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (cnt_r == LAST_IDX) begin
            drain_r <= 1'b0;
            state_r <= (op_r == OP_CLEAR) ? ST_IDLE : ST_DRAIN;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          // wait out the memory read stage and the age stage
          if (drain_r) begin
            state_r <= (op_r == OP_SELECT) ? ST_RESOLVE : ST_IDLE;
          end else begin
            drain_r <= 1'b1;
          end
        end
        ST_RESOLVE: begin
          if (stat.out_free) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/srts_dp.sv @@
// ----------------------------------------------------------------------------
// srts_dp
// Datapath: config registers, last-seen table, present flags, age pipe,
// most-recent search and sticky focus, result register.
// ----------------------------------------------------------------------------
module srts_dp import srts_pkg::*; #(
  parameter int NUM_IDS = NUM_IDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_item_t             in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat
);

  localparam int IDX_W = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;

  // Configuration
  logic [MASK_W-1:0] mask_r;
  logic [TIME_W-1:0] expire_r;

  // Table and flags
  logic [TIME_W-1:0]  mem [NUM_IDS];
  logic [NUM_IDS-1:0] seen_r, seen_nxt;
  logic [NUM_IDS-1:0] present_r, present_nxt;
  logic [ID_W-1:0]    focus_idx_r, focus_idx_nxt;
  logic               focus_held_r, focus_held_nxt;

  // Latched item
  logic [1:0]        op_r;
  logic [TIME_W-1:0] now_r;

  // Walk pipe
  logic              v1_r, v2_r;
  logic [IDX_W-1:0]  idx1_r, idx2_r;
  logic [TIME_W-1:0] rdata_r;
  logic              rseen_r;
  logic [TIME_W-1:0] age_r;

  // Search
  logic              best_found_r, best_found_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [TIME_W-1:0] best_age_r, best_age_nxt;

  // Result register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic [NUM_IDS-1:0] allowed;
  logic [IDX_W-1:0]   tid_idx, walk_a, fidx;
  logic               sight_ok;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  logic [TIME_W-1:0]  mem_wd;
  logic               keep;

  assign allowed  = mask_r[NUM_IDS-1:0];
  assign tid_idx  = in_data.target_id[IDX_W-1:0];
  assign walk_a   = cmd.walk_idx[IDX_W-1:0];
  assign fidx     = focus_idx_r[IDX_W-1:0];
  assign sight_ok = cmd.accept && (in_data.operation == OP_SIGHT) &&
                    (int'(in_data.target_id) < NUM_IDS) && allowed[tid_idx];

  assign stat.in_op    = in_data.operation;
  assign stat.out_free = !out_valid_r || !out_stall;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

  // Table write port: sighting or clear sweep
  assign mem_we = sight_ok || cmd.sweep_wr;
  assign mem_wa = cmd.sweep_wr ? walk_a : tid_idx;
  assign mem_wd = cmd.sweep_wr ? now_r : in_data.time_stamp;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.walk_rd) begin
      rdata_r <= mem[walk_a];
      rseen_r <= seen_r[walk_a];
    end
  end

  // Drop test on the aged entry
  assign keep = present_r[idx2_r] && !(age_r > expire_r) &&
                ((op_r != OP_SELECT) || allowed[idx2_r]);

  // Next state of flags, focus, search and result
  always_comb begin
    seen_nxt       = seen_r;
    present_nxt    = present_r;
    focus_idx_nxt  = focus_idx_r;
    focus_held_nxt = focus_held_r;
    best_found_nxt = best_found_r;
    best_idx_nxt   = best_idx_r;
    best_age_nxt   = best_age_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;

    // new item
    if (cmd.accept) begin
      best_found_nxt = 1'b0;
      case (in_data.operation)
        OP_SIGHT: begin
          if (sight_ok) begin
            present_nxt[tid_idx] = 1'b1;
            seen_nxt[tid_idx]    = 1'b1;
          end
        end
        OP_REFRESH: begin
          focus_held_nxt = 1'b0;
          focus_idx_nxt  = '0;
        end
        OP_CLEAR: begin
          focus_held_nxt = 1'b0;
          focus_idx_nxt  = '0;
          present_nxt    = '0;
        end
        default: ;
      endcase
    end

    // clear sweep marks entries written
    if (cmd.sweep_wr) seen_nxt[walk_a] = 1'b1;

    // drop stale or disallowed, track most recent
    if (v2_r) begin
      present_nxt[idx2_r] = keep;
      if ((op_r == OP_SELECT) && keep && (!best_found_r || (age_r < best_age_r))) begin
        best_found_nxt = 1'b1;
        best_idx_nxt   = idx2_r;
        best_age_nxt   = age_r;
      end
    end

    // result register drains
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    // sticky focus, else most recent
    if (cmd.resolve) begin
      if (!(focus_held_r && present_r[fidx])) begin
        focus_held_nxt = best_found_r;
        focus_idx_nxt  = best_found_r ? ID_W'(best_idx_r) : '0;
      end
      out_valid_nxt            = 1'b1;
      out_data_nxt.focus_found = focus_held_nxt;
      out_data_nxt.focus_id    = focus_held_nxt ? focus_idx_nxt : '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r       <= ALLOWED_RST;
      expire_r     <= EXPIRE_RST;
      seen_r       <= '0;
      present_r    <= '0;
      focus_idx_r  <= '0;
      focus_held_r <= 1'b0;
      best_found_r <= 1'b0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ALLOWED: mask_r   <= cfg_data[MASK_W-1:0];
          CFG_EXPIRE:  expire_r <= cfg_data[TIME_W-1:0];
          default: ;
        endcase
      end
      seen_r       <= seen_nxt;
      present_r    <= present_nxt;
      focus_idx_r  <= focus_idx_nxt;
      focus_held_r <= focus_held_nxt;
      best_found_r <= best_found_nxt;
      v1_r         <= cmd.walk_rd;
      v2_r         <= v1_r;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r  <= in_data.operation;
      now_r <= in_data.time_stamp;
    end
    idx1_r     <= walk_a;
    idx2_r     <= idx1_r;
    age_r      <= now_r - (rseen_r ? rdata_r : '0);
    best_idx_r <= best_idx_nxt;
    best_age_r <= best_age_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_none_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.focus_found |-> out_data_r.focus_id == '0)
    else $error("result without focus carries nonzero id");

  a_present_written: assert property (@(posedge clk) disable iff (!rst_n)
    (present_r & ~seen_r) == '0)
    else $error("present flag on a never-written entry");

  a_focus_range: assert property (@(posedge clk) disable iff (!rst_n)
    focus_held_r |-> int'(focus_idx_r) < NUM_IDS)
    else $error("focus index out of range");

  a_resolve_loads: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.resolve |=> out_valid_r)
    else $error("resolve did not load result register");
`endif

endmodule

@@ hdl/sticky_recent_target_selector.sv @@
// ----------------------------------------------------------------------------
// sticky_recent_target_selector
// Tracks last sighting per target id and keeps a sticky focus target.
//
// Input channel in_valid/in_stall/in_data carries one operation per item:
// sighting, select, refresh or clear. Only select produces a result item on
// out_valid/out_stall/out_data (focus id and found flag). The cfg_ port
// writes allowed_mask (index 0) and expire_ticks (index 1); the user must
// write them only while idle, the block itself does not enforce this. A
// sighting needs no walk. Select and refresh walk the last-seen table
// through its single read port and a two-stage age pipe; clear walks it
// through the write port. One item is in work at a time; in_stall is high
// while it runs. Synchronous reset empties the table, clears the focus and
// restores the register defaults; no clearing pass is needed. A stalled
// result holds in the output register; a new item is still accepted, and a
// following select waits at its end until the register frees.
// ----------------------------------------------------------------------------
module sticky_recent_target_selector import srts_pkg::*; #(
  parameter int NUM_IDS = NUM_IDS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer
  srts_ctrl #(.NUM_IDS(NUM_IDS)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Table, search and result
  srts_dp #(.NUM_IDS(NUM_IDS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
